/* src/vnt_pkg.sv */
// Shared constants, types and table builders for the value-noise texture block.
package vnt_pkg;

  // Field and datapath widths.
  localparam int COORD_W     = 10;
  localparam int ADDR_W      = 20;
  localparam int FWIDTH_W    = 11;
  localparam int PERSIST_W   = 15;
  localparam int OCT_W       = 4;
  localparam int DIV_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 3;

  // Octave limits and the coordinate scaling that the divider works with.
  localparam int MAX_OCTAVES = 8;
  localparam int FRAC_W      = 16;
  localparam int DIV_SHIFT   = 24 + MAX_OCTAVES - 1;
  localparam int QUO_W       = COORD_W + DIV_SHIFT;

  // Noise and accumulation widths.
  localparam int NOISE_W  = 32;
  localparam int AMP_W    = 22;
  localparam int AMP_FRAC = 14;
  localparam int TOTAL_W  = 44;
  localparam int SUM_W    = 36;

  // Lattice grid held in the tap chain: four by four points around a sample.
  localparam int GRID = 4;
  localparam int TAPS = GRID * GRID;

  // Cosine weight table.
  localparam int COS_ENTRIES = 1024;
  localparam int COS_IDX_W   = $clog2(COS_ENTRIES);

  // Lattice hash constants.
  localparam logic [WORD_W-1:0] HASH_MUL_Y = 32'd57;
  localparam int                HASH_SHIFT = 13;
  localparam logic [WORD_W-1:0] HASH_K1    = 32'd15731;
  localparam logic [WORD_W-1:0] HASH_K2    = 32'd789221;
  localparam logic [WORD_W-1:0] HASH_K3    = 32'd1376312589;

  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint PI_Q30  = 64'sd3373259426;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PERSISTENCE  = 3'd0,
    CFG_OCTAVE_COUNT = 3'd1,
    CFG_ZOOM         = 3'd2,
    CFG_RED_GAIN     = 3'd3,
    CFG_GREEN_GAIN   = 3'd4,
    CFG_BLUE_GAIN    = 3'd5,
    CFG_NOISE_SEED   = 3'd6,
    CFG_FRAME_WIDTH  = 3'd7
  } cfg_index_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETUP,
    ST_HASH,
    ST_SMOOTH,
    ST_BLEND,
    ST_COLOR,
    ST_EMIT
  } state_t;

  typedef logic [FRAC_W:0] cos_word_t;
  typedef cos_word_t cos_table_t [COS_ENTRIES];

  // Taylor series divisors (2j)(2j-1) for j = 0..6; entry 0 is unused.
  localparam longint TaylorDiv [7] = '{1, 2, 12, 30, 56, 90, 132};

  // One entry of the raised-cosine weight table, (1-cos(pi*k/N))/2 in Q16.
  function automatic cos_word_t cos_entry(int k);
    longint h;
    longint u;
    longint u2;
    longint c;
    longint p;
    longint w;
    bit     mirror;
    h      = k;
    mirror = 1'b0;
    if (2 * k > COS_ENTRIES) begin
      h      = COS_ENTRIES - k;
      mirror = 1'b1;
    end
    u  = (PI_Q30 * h) / COS_ENTRIES;
    u2 = (u * u) >>> 30;
    c  = Q30_ONE;
    for (int j = 6; j >= 1; j--) begin
      p = (u2 * c) >>> 30;
      c = Q30_ONE - p / TaylorDiv[j];
      if (c < 0) c = 0;
    end
    w = (Q30_ONE - c) >>> 15;
    if (mirror) w = 65536 - w;
    return cos_word_t'(w);
  endfunction

  // Whole weight table, built at elaboration.
  function automatic cos_table_t build_cos_table();
    cos_table_t t;
    for (int k = 0; k < COS_ENTRIES; k++) t[k] = cos_entry(k);
    return t;
  endfunction

endpackage

/* src/vnt_tap_cell.sv */
// One cell of the lattice noise chain: holds a word and passes it on when shifting.
module vnt_tap_cell (
  input  logic                                 clk,
  input  logic                                 shift,
  input  logic signed [vnt_pkg::NOISE_W-1:0]   d,
  output logic signed [vnt_pkg::NOISE_W-1:0]   q
);
  import vnt_pkg::*;

  // The word moves one cell down the chain on each new hash result.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

/* src/vnt_hash.sv */
// Four-stage pipelined integer lattice hash giving Q2.30 noise.
module vnt_hash (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic        [vnt_pkg::WORD_W-1:0]   x,
  input  logic        [vnt_pkg::WORD_W-1:0]   y,
  input  logic        [vnt_pkg::WORD_W-1:0]   seed,
  output logic                                done,
  output logic signed [vnt_pkg::NOISE_W-1:0]  noise
);
  import vnt_pkg::*;

  logic [3:0]        vpipe;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] n0;
  logic [WORD_W-1:0] n1;
  logic [WORD_W-1:0] n2;
  logic [WORD_W-1:0] sq;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] m;

  // Valid bits follow the words through the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[2:0], start};
    end
  end

  assign base = x + y * HASH_MUL_Y + seed;
  assign m    = n2 * t2 + HASH_K3;

  // Mix, square, polynomial, then the final product; all arithmetic wraps at 32 bits.
  always_ff @(posedge clk) begin
    n0    <= base ^ (base << HASH_SHIFT);
    sq    <= n0 * n0;
    n1    <= n0;
    t2    <= sq * HASH_K1 + HASH_K2;
    n2    <= n1;
    noise <= $signed(NOISE_W'(Q30_ONE)) - $signed({1'b0, m[WORD_W-2:0]});
  end

  assign done = vpipe[3];

endmodule

/* src/vnt_divider.sv */
// Radix-2 restoring divider that scales both coordinates by the zoom divisor.
module vnt_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [vnt_pkg::COORD_W-1:0]       col,
  input  logic [vnt_pkg::COORD_W-1:0]       row,
  input  logic [vnt_pkg::DIV_W-1:0]         divisor,
  output logic                              done,
  output logic [vnt_pkg::QUO_W-1:0]         quo_x,
  output logic [vnt_pkg::QUO_W-1:0]         quo_y
);
  import vnt_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dv;
  logic [COORD_W-1:0] num [2];
  logic [DIV_W-1:0]   rem [2];
  logic [QUO_W-1:0]   quo [2];
  logic [DIV_W:0]     trial [2];
  logic               ge [2];

  // Trial subtraction for both lanes; the numerator's low zeros shift in after the coordinate.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem[l], num[l][COORD_W-1]};
      ge[l]    = trial[l] >= {1'b0, dv};
    end
  end

  // Step counter: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num[0] <= col;
      num[1] <= row;
      rem[0] <= '0;
      rem[1] <= '0;
      dv     <= divisor;
    end else if (running) begin
      for (int l = 0; l < 2; l++) begin
        num[l] <= num[l] << 1;
        rem[l] <= ge[l] ? DIV_W'(trial[l] - {1'b0, dv}) : trial[l][DIV_W-1:0];
        quo[l] <= {quo[l][QUO_W-2:0], ge[l]};
      end
    end
  end

  assign quo_x = quo[0];
  assign quo_y = quo[1];

endmodule

/* src/value_noise_texture_pixel.sv */
// Top level of the value-noise texture pixel generator.
// Each accepted coordinate word yields one ARGB word and its frame address. A pixel runs
// through the bit-serial coordinate divider, then, for each of N octaves, where N is the
// octave count (at most 8), 16 lattice hashes through a shared four-stage hash pipeline
// into a sixteen-cell noise chain, smoothing, and cosine blending on one shared multiplier.
// A new coordinate is taken as soon as the previous pixel has moved into the output
// register; no reset sweep is needed.
module value_noise_texture_pixel (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [vnt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vnt_pkg::WORD_W-1:0]         cfg_data,
  input  logic                               coord_valid,
  output logic                               coord_ready,
  input  logic [vnt_pkg::COORD_W-1:0]        col,
  input  logic [vnt_pkg::COORD_W-1:0]        row,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [vnt_pkg::WORD_W-1:0]         argb_word,
  output logic [vnt_pkg::ADDR_W-1:0]         pixel_address
);
  import vnt_pkg::*;

  localparam cos_table_t CosTable = build_cos_table();
  localparam int         STEP_W   = 4;

  // Configuration registers.
  logic [PERSIST_W-1:0] persistence;
  logic [OCT_W-1:0]     octave_count;
  logic [DIV_W-1:0]     zoom;
  logic [GAIN_W-1:0]    gains [3];
  logic [WORD_W-1:0]    noise_seed;
  logic [FWIDTH_W-1:0]  frame_width;

  // Sequencer.
  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [OCT_W-1:0]  oct;
  logic [OCT_W-1:0]  oct_count;
  logic [4:0]        hash_issue;
  logic [4:0]        hash_recv;
  logic              div_start;
  logic              hash_start;

  // Pixel datapath.
  logic [COORD_W-1:0]        col_r;
  logic [COORD_W-1:0]        row_r;
  logic                      div_done;
  logic [QUO_W-1:0]          quo_x;
  logic [QUO_W-1:0]          quo_y;
  logic [QUO_W-1:0]          sx;
  logic [QUO_W-1:0]          sy;
  logic [WORD_W-1:0]         ix;
  logic [WORD_W-1:0]         iy;
  logic [FRAC_W-1:0]         fx;
  logic [FRAC_W-1:0]         fy;
  logic [WORD_W-1:0]         hash_x;
  logic [WORD_W-1:0]         hash_y;
  logic                      hash_done;
  logic signed [NOISE_W-1:0] hash_noise;
  logic signed [NOISE_W-1:0] taps [TAPS];

  logic signed [SUM_W-1:0]   corner_l [4];
  logic signed [SUM_W-1:0]   side_l [4];
  logic signed [SUM_W-1:0]   corner_r;
  logic signed [SUM_W-1:0]   side_r;
  logic signed [NOISE_W-1:0] ctr_r;
  logic signed [SUM_W-1:0]   smooth_sum;
  logic signed [NOISE_W-1:0] smv [4];
  logic [1:0]                smooth_sel;

  logic [COS_IDX_W-1:0]      rom_addr;
  logic [FRAC_W:0]           rom_q;
  logic [FRAC_W:0]           wx;
  logic [FRAC_W:0]           wy;
  logic signed [NOISE_W:0]   mul_a;
  logic [FRAC_W:0]           mul_w;
  logic signed [NOISE_W+FRAC_W+1:0] prod;
  logic signed [NOISE_W-1:0] pa;
  logic signed [NOISE_W-1:0] h1;
  logic signed [NOISE_W-1:0] h2;
  logic signed [NOISE_W-1:0] nval;
  logic signed [SUM_W-1:0]   blend_sum;
  logic [AMP_W-1:0]          amp;
  logic [AMP_W+PERSIST_W-1:0] amp_prod;
  logic signed [NOISE_W+AMP_W:0] term;
  logic signed [TOTAL_W-1:0] total;

  logic signed [TOTAL_W:0]   vpos;
  logic                      vpos_pos;
  logic [23:0]               gmul [3];
  logic [47:0]               ghi [3];
  logic [43:0]               glo [3];
  logic [48:0]               chan_sum [3];
  logic [7:0]                chan [3];
  logic [ADDR_W-1:0]         addr_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      persistence  <= PERSIST_W'(8192);
      octave_count <= OCT_W'(4);
      zoom         <= DIV_W'(256);
      gains[0]     <= GAIN_W'(32768);
      gains[1]     <= GAIN_W'(32768);
      gains[2]     <= GAIN_W'(32768);
      noise_seed   <= '0;
      frame_width  <= FWIDTH_W'(256);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PERSISTENCE:  persistence  <= cfg_data[PERSIST_W-1:0];
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[OCT_W-1:0];
        CFG_ZOOM:         zoom         <= cfg_data[DIV_W-1:0];
        CFG_RED_GAIN:     gains[0]     <= cfg_data[GAIN_W-1:0];
        CFG_GREEN_GAIN:   gains[1]     <= cfg_data[GAIN_W-1:0];
        CFG_BLUE_GAIN:    gains[2]     <= cfg_data[GAIN_W-1:0];
        CFG_NOISE_SEED:   noise_seed   <= cfg_data;
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next  = state;
    coord_ready = 1'b0;
    div_start   = 1'b0;
    hash_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        coord_ready = 1'b1;
        if (coord_valid) begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) state_next = (oct_count == '0) ? ST_COLOR : ST_SETUP;
      end
      ST_SETUP: state_next = ST_HASH;
      ST_HASH: begin
        hash_start = (hash_issue != 5'(TAPS));
        if (hash_done && hash_recv == 5'(TAPS - 1)) state_next = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        if (step == STEP_W'(7)) state_next = ST_BLEND;
      end
      ST_BLEND: begin
        if (step == STEP_W'(8)) begin
          state_next = (oct + 1'b1 == oct_count) ? ST_COLOR : ST_SETUP;
        end
      end
      ST_COLOR: begin
        if (step == STEP_W'(2)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!result_valid || result_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Step, octave and hash counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      oct        <= '0;
      oct_count  <= '0;
      hash_issue <= '0;
      hash_recv  <= '0;
    end else begin
      step <= (state_next != state) ? '0 : step + 1'b1;
      if (div_start) begin
        oct       <= '0;
        oct_count <= (octave_count > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : octave_count;
      end else if (state == ST_BLEND && step == STEP_W'(8)) begin
        oct <= oct + 1'b1;
      end
      if (state == ST_SETUP) begin
        hash_issue <= '0;
        hash_recv  <= '0;
      end else begin
        if (hash_start) hash_issue <= hash_issue + 1'b1;
        if (hash_done)  hash_recv  <= hash_recv + 1'b1;
      end
    end
  end

  // Coordinate latch and scaling divider.
  always_ff @(posedge clk) begin
    if (div_start) begin
      col_r <= col;
      row_r <= row;
    end
  end

  vnt_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .col     (col),
    .row     (row),
    .divisor ((zoom == '0) ? DIV_W'(1) : zoom),
    .done    (div_done),
    .quo_x   (quo_x),
    .quo_y   (quo_y)
  );

  // Sample point of this octave: the full-scale quotient shifted down.
  assign sx = quo_x >> (3'(MAX_OCTAVES - 1) - oct[2:0]);
  assign sy = quo_y >> (3'(MAX_OCTAVES - 1) - oct[2:0]);

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      ix <= WORD_W'(sx >> FRAC_W);
      iy <= WORD_W'(sy >> FRAC_W);
      fx <= sx[FRAC_W-1:0];
      fy <= sy[FRAC_W-1:0];
    end
  end

  // Lattice points from one below to two above the sample, row by row.
  assign hash_x = ix + WORD_W'(hash_issue[1:0]) - 1'b1;
  assign hash_y = iy + WORD_W'(hash_issue[3:2]) - 1'b1;

  vnt_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .x     (hash_x),
    .y     (hash_y),
    .seed  (noise_seed),
    .done  (hash_done),
    .noise (hash_noise)
  );

  // Noise chain: the newest hash enters cell 0, the oldest sits in the last cell.
  for (genvar c = 0; c < TAPS; c++) begin : g_chain
    vnt_tap_cell u_cell (
      .clk   (clk),
      .shift (hash_done),
      .d     ((c == 0) ? hash_noise : taps[(c == 0) ? 0 : c - 1]),
      .q     (taps[c])
    );
  end

  // Corner and side sums for each of the four smoothed lattice points.
  always_comb begin
    int ox;
    int oy;
    for (int q = 0; q < 4; q++) begin
      ox = q & 1;
      oy = q >> 1;
      corner_l[q] = SUM_W'(taps[TAPS-1 - (oy * GRID + ox)])
                  + SUM_W'(taps[TAPS-1 - (oy * GRID + ox + 2)])
                  + SUM_W'(taps[TAPS-1 - ((oy + 2) * GRID + ox)])
                  + SUM_W'(taps[TAPS-1 - ((oy + 2) * GRID + ox + 2)]);
      side_l[q]   = SUM_W'(taps[TAPS-1 - ((oy + 1) * GRID + ox)])
                  + SUM_W'(taps[TAPS-1 - ((oy + 1) * GRID + ox + 2)])
                  + SUM_W'(taps[TAPS-1 - (oy * GRID + ox + 1)])
                  + SUM_W'(taps[TAPS-1 - ((oy + 2) * GRID + ox + 1)]);
    end
  end

  assign smooth_sel = step[2:1];
  assign smooth_sum = corner_r + (side_r <<< 1) + (SUM_W'(ctr_r) <<< 2);

  // Smoothing: partial sums on even steps, weighted total on the odd step after.
  always_ff @(posedge clk) begin
    if (state == ST_SMOOTH) begin
      if (!step[0]) begin
        corner_r <= corner_l[smooth_sel];
        side_r   <= side_l[smooth_sel];
        ctr_r    <= taps[smooth_sel[1] ? (smooth_sel[0] ? TAPS-1 - (2 * GRID + 2)
                                                        : TAPS-1 - (2 * GRID + 1))
                                       : (smooth_sel[0] ? TAPS-1 - (GRID + 2)
                                                        : TAPS-1 - (GRID + 1))];
      end else begin
        smv[smooth_sel] <= NOISE_W'(smooth_sum >>> 4);
      end
    end
  end

  // Cosine weight table with a registered read.
  assign rom_addr = (step == '0) ? fx[FRAC_W-1 -: COS_IDX_W] : fy[FRAC_W-1 -: COS_IDX_W];

  always_ff @(posedge clk) begin
    rom_q <= CosTable[rom_addr];
  end

  // Operands of the shared blend multiplier.
  always_comb begin
    unique case (step)
      STEP_W'(2): begin
        mul_a = (NOISE_W+1)'(smv[1]) - (NOISE_W+1)'(smv[0]);
        mul_w = wx;
      end
      STEP_W'(3): begin
        mul_a = (NOISE_W+1)'(smv[3]) - (NOISE_W+1)'(smv[2]);
        mul_w = wx;
      end
      default: begin
        mul_a = (NOISE_W+1)'(h2) - (NOISE_W+1)'(h1);
        mul_w = wy;
      end
    endcase
  end

  assign blend_sum = SUM_W'(pa) + SUM_W'(prod >>> FRAC_W);
  assign amp_prod  = amp * persistence;

  // Blend along x twice, then along y, then weight by amplitude and accumulate.
  always_ff @(posedge clk) begin
    if (div_start) begin
      amp   <= AMP_W'(1 << AMP_FRAC);
      total <= '0;
    end else if (state == ST_BLEND) begin
      unique case (step)
        STEP_W'(1): wx <= rom_q;
        STEP_W'(2): begin
          wy   <= rom_q;
          prod <= mul_a * $signed({1'b0, mul_w});
          pa   <= smv[0];
        end
        STEP_W'(3): begin
          h1   <= NOISE_W'(blend_sum);
          prod <= mul_a * $signed({1'b0, mul_w});
          pa   <= smv[2];
        end
        STEP_W'(4): h2 <= NOISE_W'(blend_sum);
        STEP_W'(5): begin
          prod <= mul_a * $signed({1'b0, mul_w});
          pa   <= h1;
        end
        STEP_W'(6): nval <= NOISE_W'(blend_sum);
        STEP_W'(7): term <= nval * $signed({1'b0, amp});
        STEP_W'(8): begin
          total <= total + TOTAL_W'(term >>> AMP_FRAC);
          amp   <= AMP_W'(amp_prod >> AMP_FRAC);
        end
        default: ;
      endcase
    end
  end

  // Channel scaling lanes: gain*255*(total+1), split into high and low products.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gmul[c]     = {gains[c], 8'd0} - 24'(gains[c]);
      chan_sum[c] = 49'(ghi[c]) + 49'(glo[c] >> 20);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COLOR) begin
      unique case (step)
        STEP_W'(0): vpos <= (TOTAL_W+1)'(total) + (TOTAL_W+1)'(Q30_ONE);
        STEP_W'(1): begin
          vpos_pos <= (vpos > 0);
          addr_r   <= ADDR_W'(row_r * frame_width + 21'(col_r));
          for (int c = 0; c < 3; c++) begin
            ghi[c] <= gmul[c] * vpos[TOTAL_W-1:20];
            glo[c] <= gmul[c] * vpos[19:0];
          end
        end
        default: begin
          for (int c = 0; c < 3; c++) begin
            if (!vpos_pos) begin
              chan[c] <= '0;
            end else if ((chan_sum[c] >> 26) > 49'd255) begin
              chan[c] <= 8'hFF;
            end else begin
              chan[c] <= chan_sum[c][33:26];
            end
          end
        end
      endcase
    end
  end

  // Output register: holds a finished word while the next pixel is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EMIT && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!result_valid || result_ready)) begin
      argb_word     <= {8'hFF, chan[0], chan[1], chan[2]};
      pixel_address <= addr_r;
    end
  end

  // Hash results only arrive while the chain is being filled.
  assert property (@(posedge clk) disable iff (rst) hash_done |-> state == ST_HASH)
    else $error("hash result outside the fill phase");

  // Smoothing starts only with a completely filled chain.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SMOOTH && step == '0) |-> hash_recv == 5'(TAPS))
    else $error("smoothing started on a partly filled chain");

  // The octave counter never passes the latched octave count.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SETUP || state == ST_BLEND) |-> oct < oct_count)
    else $error("octave counter out of range");

  // Every delivered word carries an opaque alpha.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> argb_word[31:24] == 8'hFF)
    else $error("alpha byte is not opaque");

endmodule

/* tb/sv/tb_value_noise_texture_pixel.sv */
// Self-checking testbench for the value-noise texture pixel generator.
`timescale 1ns / 1ps

module tb_value_noise_texture_pixel;
  import vnt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int LONG_HOLD      = 2000;

  typedef struct {
    logic [WORD_W-1:0] argb;
    logic [ADDR_W-1:0] addr;
  } texel_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_data;
  logic                   coord_valid;
  logic                   coord_ready;
  logic [COORD_W-1:0]     col;
  logic [COORD_W-1:0]     row;
  logic                   result_valid;
  logic                   result_ready;
  logic [WORD_W-1:0]      argb_word;
  logic [ADDR_W-1:0]      pixel_address;

  value_noise_texture_pixel dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .coord_valid(coord_valid), .coord_ready(coord_ready), .col(col), .row(row),
    .result_valid(result_valid), .result_ready(result_ready),
    .argb_word(argb_word), .pixel_address(pixel_address)
  );

  // Mirror of the register file as the block should hold it.
  int          persist_r;
  int          octaves_r;
  int          zoom_r;
  int          gain_r [3];
  bit [31:0]   seed_r;
  int          fwidth_r;

  longint      cos_weight_tab [COS_ENTRIES];
  bit [19:0]   coord_queue [$];
  texel_t      texel_queue [$];
  int          issued_n;
  int          accepted_n;
  int          error_count;
  int          idle_cycles;
  bit          calm;
  int          rx_hold_req;
  int          rx_hold_seen;
  int          rx_hold_left;

  always #5 clk = ~clk;

  // Raised-cosine weight (1-cos(pi*k/N))/2 in Q16, by a six-term series.
  function automatic longint cos_weight(int k);
    longint h, u, u2, c, p, w;
    bit     flip;
    h    = k;
    flip = 1'b0;
    if (2 * k > COS_ENTRIES) begin
      h    = COS_ENTRIES - k;
      flip = 1'b1;
    end
    u  = (64'sd3373259426 * h) / COS_ENTRIES;
    u2 = (u * u) >>> 30;
    c  = 64'sd1 << 30;
    for (int j = 6; j >= 1; j--) begin
      p = (u2 * c) >>> 30;
      c = (64'sd1 << 30) - p / ((2 * j) * (2 * j - 1));
      if (c < 0) c = 0;
    end
    w = ((64'sd1 << 30) - c) >>> 15;
    return flip ? 65536 - w : w;
  endfunction

  // Lattice hash noise in Q2.30.
  function automatic longint lattice_value(bit [31:0] x, bit [31:0] y);
    bit [31:0] n;
    bit [31:0] m;
    n = x + y * 32'd57 + seed_r;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return (64'sd1 << 30) - $signed({32'b0, m});
  endfunction

  // Nine-point smoothing around one lattice point.
  function automatic longint smoothed_lattice(bit [31:0] x, bit [31:0] y);
    longint corners, sides, center;
    corners = lattice_value(x - 32'd1, y - 32'd1) + lattice_value(x + 32'd1, y - 32'd1)
            + lattice_value(x - 32'd1, y + 32'd1) + lattice_value(x + 32'd1, y + 32'd1);
    sides   = lattice_value(x - 32'd1, y) + lattice_value(x + 32'd1, y)
            + lattice_value(x, y - 32'd1) + lattice_value(x, y + 32'd1);
    center  = lattice_value(x, y);
    return (corners + 2 * sides + 4 * center) >>> 4;
  endfunction

  // Cosine blend between two values by a 16-bit fraction.
  function automatic longint cos_mix(longint a, longint b, int frac);
    return a + (((b - a) * cos_weight_tab[frac >> 6]) >>> 16);
  endfunction

  // One color channel from the summed noise, saturated to a byte.
  function automatic logic [7:0] channel_level(int gain, longint v);
    bit [63:0] g, hi, lo, r;
    if (v <= 0) return 8'd0;
    g  = 64'(gain) * 64'd255;
    hi = 64'(v) >> 20;
    lo = 64'(v) & 64'hfffff;
    r  = (g * hi + ((g * lo) >> 20)) >> 26;
    return r > 255 ? 8'd255 : r[7:0];
  endfunction

  // Full texel for one coordinate under the current register settings.
  function automatic texel_t shade_texel(bit [9:0] c, bit [9:0] r);
    bit [63:0] divisor, sx, sy;
    bit [31:0] ix, iy;
    int        fx, fy, count;
    longint    amp, total, n, v;
    texel_t    t;
    divisor = (zoom_r == 0) ? 64'd1 : 64'(zoom_r);
    count   = (octaves_r > MAX_OCTAVES) ? MAX_OCTAVES : octaves_r;
    amp     = 64'sd1 << 14;
    total   = 0;
    for (int i = 0; i < count; i++) begin
      sx = (64'(c) << (i + 24)) / divisor;
      sy = (64'(r) << (i + 24)) / divisor;
      ix = sx[47:16];
      iy = sy[47:16];
      fx = int'(sx[15:0]);
      fy = int'(sy[15:0]);
      n  = cos_mix(cos_mix(smoothed_lattice(ix, iy), smoothed_lattice(ix + 32'd1, iy), fx),
                   cos_mix(smoothed_lattice(ix, iy + 32'd1),
                           smoothed_lattice(ix + 32'd1, iy + 32'd1), fx), fy);
      total += (n * amp) >>> 14;
      amp = (amp * persist_r) >>> 14;
    end
    v = total + (64'sd1 << 30);
    t.argb = {8'hff, channel_level(gain_r[0], v), channel_level(gain_r[1], v),
              channel_level(gain_r[2], v)};
    t.addr = ADDR_W'(r * fwidth_r + c);
    return t;
  endfunction

  // Coordinate driver: a new word is offered only after the last one was taken.
  always @(negedge clk) begin
    if (rst) begin
      coord_valid <= 1'b0;
    end else if (!coord_valid || accepted_n == issued_n) begin
      if (coord_queue.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
        {col, row}  <= coord_queue.pop_front();
        coord_valid <= 1'b1;
        issued_n    <= issued_n + 1;
      end else begin
        coord_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure, with an occasional long hold to fill the block.
  always @(negedge clk) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= LONG_HOLD;
      result_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || $urandom_range(99) >= 9;
    end
  end

  // Monitor: predict on each taken coordinate, compare each delivered word.
  always @(posedge clk) begin
    texel_t want;
    bit     took;
    took = 1'b0;
    if (!rst && result_valid && result_ready) begin
      took = 1'b1;
      if (texel_queue.size() == 0) begin
        $error("unexpected result argb_word=%h pixel_address=%h", argb_word, pixel_address);
        error_count++;
      end else begin
        want = texel_queue.pop_front();
        if (argb_word !== want.argb) begin
          $error("argb_word expected %h actual %h", want.argb, argb_word);
          error_count++;
        end
        if (pixel_address !== want.addr) begin
          $error("pixel_address expected %h actual %h", want.addr, pixel_address);
          error_count++;
        end
      end
    end
    if (!rst && coord_valid && coord_ready) begin
      took = 1'b1;
      texel_queue.push_back(shade_texel(col, row));
      accepted_n <= accepted_n + 1;
    end
    idle_cycles <= took ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Register write at the falling edge; the mirror follows the field widths.
  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_PERSISTENCE:  persist_r = int'(value[14:0]);
      CFG_OCTAVE_COUNT: octaves_r = int'(value[3:0]);
      CFG_ZOOM:         zoom_r    = int'(value[15:0]);
      CFG_RED_GAIN:     gain_r[0] = int'(value[15:0]);
      CFG_GREEN_GAIN:   gain_r[1] = int'(value[15:0]);
      CFG_BLUE_GAIN:    gain_r[2] = int'(value[15:0]);
      CFG_NOISE_SEED:   seed_r    = value;
      CFG_FRAME_WIDTH:  fwidth_r  = int'(value[10:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(int pers, int oct, int zm, int gr, int gg, int gb,
                           logic [31:0] seed, int fw);
    write_reg(CFG_PERSISTENCE, pers);
    write_reg(CFG_OCTAVE_COUNT, oct);
    write_reg(CFG_ZOOM, zm);
    write_reg(CFG_RED_GAIN, gr);
    write_reg(CFG_GREEN_GAIN, gg);
    write_reg(CFG_BLUE_GAIN, gb);
    write_reg(CFG_NOISE_SEED, seed);
    write_reg(CFG_FRAME_WIDTH, fw);
  endtask

  // Corner, edge and checkerboard coordinates.
  task automatic push_directed();
    coord_queue.push_back({10'd0, 10'd0});
    coord_queue.push_back({10'd1023, 10'd1023});
    coord_queue.push_back({10'd1023, 10'd0});
    coord_queue.push_back({10'd0, 10'd1023});
    coord_queue.push_back({10'd1, 10'd1});
    coord_queue.push_back({10'd512, 10'd511});
    coord_queue.push_back({10'h2aa, 10'h155});
    coord_queue.push_back({10'h155, 10'h2aa});
  endtask

  task automatic push_random(int n);
    repeat (n) coord_queue.push_back(20'($urandom));
  endtask

  // Hold the sender until every expected word has come back.
  task automatic drain();
    while (coord_queue.size() != 0 || accepted_n != issued_n || texel_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0; rst = 1'b1; cfg_write = 1'b0; cfg_index = CFG_PERSISTENCE; cfg_data = '0;
    coord_valid = 1'b0; col = '0; row = '0; result_ready = 1'b0;
    issued_n = 0; accepted_n = 0; error_count = 0; idle_cycles = 0; calm = 1'b0;
    rx_hold_req = 0; rx_hold_seen = 0; rx_hold_left = 0;
    persist_r = 8192; octaves_r = 4; zoom_r = 256;
    gain_r[0] = 32768; gain_r[1] = 32768; gain_r[2] = 32768;
    seed_r = '0; fwidth_r = 256;
    for (int k = 0; k < COS_ENTRIES; k++) cos_weight_tab[k] = cos_weight(k);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings.
    push_directed();
    push_random(40);
    drain();

    // Lower extremes: no octaves, zero gains, smallest zoom, zero frame width.
    write_all(0, 0, 1, 0, 0, 0, 32'h0000_0000, 0);
    push_directed();
    push_random(30);
    drain();

    // Upper extremes: too many octaves, large gains, zoom zero, widest frame.
    write_all(32767, 15, 0, 65535, 65535, 65535, 32'h8000_0000, 2047);
    push_directed();
    push_random(30);
    drain();

    write_all(32767, 8, 65535, 32768, 1, 40000, 32'h7fff_ffff, 1024);
    push_random(30);
    drain();

    // Random settings; one phase runs calm, one with a long result hold.
    for (int ph = 0; ph < 8; ph++) begin
      write_all($urandom_range(0, 32767), $urandom_range(0, 15),
                ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(16, 2048),
                $urandom_range(0, 65535), $urandom_range(0, 40000), $urandom_range(0, 32768),
                $urandom, $urandom_range(0, 2047));
      calm = (ph == 2);
      if (ph == 4) rx_hold_req = rx_hold_req + 1;
      push_random(75);
      drain();
    end

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
